### rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// shared types, register indexes and saturating helpers for the pid step block
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int DATA_W        = 32;
    localparam int WIDE_W        = DATA_W + 2;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;

    typedef logic signed [DATA_W-1:0] t_q;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INT_GAIN    = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_PERIOD_US   = 3'd3,
        CFG_INT_MIN     = 3'd4,
        CFG_INT_MAX     = 3'd5,
        CFG_OUT_MIN     = 3'd6,
        CFG_OUT_MAX     = 3'd7
    } t_cfg_idx;

    function automatic t_wide ext(input t_q v);
        ext = {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic t_q sat(input t_wide v);
        logic [WIDE_W-DATA_W:0] top;
        top = v[WIDE_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            sat = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    function automatic t_q limit(input t_q v, input t_q lo, input t_q hi);
        if (v < lo) begin
            limit = lo;
        end else if (v > hi) begin
            limit = hi;
        end else begin
            limit = v;
        end
    endfunction

endpackage

### rtl/pidc_if.sv
// ----------------------------------------------------------------------------
// pidc interfaces
// sample, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface pidc_in_if;
    logic            valid;
    logic            ready;
    pidc_pkg::t_q    measurement;
    pidc_pkg::t_q    target;
    logic [31:0]     time_us;

    modport source (output valid, output measurement, output target, output time_us,
                    input ready);
    modport sink   (input valid, input measurement, input target, input time_us,
                    output ready);
endinterface

interface pidc_out_if;
    logic            valid;
    logic            ready;
    pidc_pkg::t_q    drive;
    logic            ran;
    pidc_pkg::t_q    error_now;
    pidc_pkg::t_q    deriv_term;

    modport source (output valid, output drive, output ran, output error_now,
                    output deriv_term, input ready);
    modport sink   (input valid, input drive, input ran, input error_now,
                    input deriv_term, output ready);
endinterface

interface pidc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pidc_pkg::CFG_IDX_W-1:0]      index;
    logic [pidc_pkg::DATA_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pidc_qmul.sv
// ----------------------------------------------------------------------------
// pidc_qmul
// signed fixed point multiply, floor of the scaled product, saturated to 32 bits
// ----------------------------------------------------------------------------
module pidc_qmul #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  pidc_pkg::t_q i_a,
    input  pidc_pkg::t_q i_b,
    output pidc_pkg::t_q o_y
);

    localparam int PROD_W = 2 * pidc_pkg::DATA_W;

    logic signed [PROD_W-1:0]                        w_prod;
    logic signed [PROD_W-1:0]                        w_shift;
    logic [PROD_W-pidc_pkg::DATA_W:0]                w_top;

    assign w_prod  = PROD_W'(i_a) * PROD_W'(i_b);
    assign w_shift = w_prod >>> FRAC_BITS;
    assign w_top   = w_shift[PROD_W-1:pidc_pkg::DATA_W-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            o_y = w_shift[pidc_pkg::DATA_W-1:0];
        end else if (w_shift[PROD_W-1]) begin
            o_y = {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
        end
    end

endmodule

### rtl/pid_step_with_clamps_top.sv
// ----------------------------------------------------------------------------
// pid_step_with_clamps_top
// pid controller step with period gate, clamped integral and clamped output
// ----------------------------------------------------------------------------
//  channel  dir  beat payload                                   handshake
//  i_cfg    in   index (0..7), data (32)                        valid/ready
//  i_in     in   measurement, target (Q16.16), time_us          valid/ready
//  o_out    out  drive, ran, error_now, deriv_term              valid/ready
//
//  one beat per cycle sustained while o_out is not stalled; a beat passes through
//  the input register and then the result register before it is offered on o_out
//  the controller state recurrence closes through three multipliers,
//  the saturating adds and the clamps between input and result registers
//  synchronous active-low reset clears configuration, controller state and valid flags to zero
//  o_out stall holds the result register; the input register still takes a beat while empty
//  register writes are always ready
// ----------------------------------------------------------------------------
module pid_step_with_clamps_top #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pidc_cfg_if.sink           i_cfg,
    pidc_in_if.sink            i_in,
    pidc_out_if.source         o_out
);

    // configuration
    pidc_pkg::t_q r_prop_gain;
    pidc_pkg::t_q r_int_gain;
    pidc_pkg::t_q r_deriv_gain;
    logic [31:0]  r_period_us;
    pidc_pkg::t_q r_int_min;
    pidc_pkg::t_q r_int_max;
    pidc_pkg::t_q r_out_min;
    pidc_pkg::t_q r_out_max;

    // controller state
    pidc_pkg::t_q r_last_error;
    pidc_pkg::t_q r_integral_acc;
    pidc_pkg::t_q r_held_output;
    pidc_pkg::t_q r_held_deriv;
    logic [31:0]  r_last_run_time;

    // input register
    logic         r_in_valid;
    pidc_pkg::t_q r_meas;
    pidc_pkg::t_q r_tgt;
    logic [31:0]  r_time;

    // result register
    logic         r_out_valid;
    pidc_pkg::t_q r_out_drive;
    logic         r_out_ran;
    pidc_pkg::t_q r_out_error;
    pidc_pkg::t_q r_out_deriv;

    logic         w_advance;
    logic         w_load;
    logic [31:0]  w_elapsed;
    logic         w_run;
    pidc_pkg::t_q w_err;
    pidc_pkg::t_q w_diff;
    pidc_pkg::t_q w_deriv;
    pidc_pkg::t_q w_prop;
    pidc_pkg::t_q w_inc;
    pidc_pkg::t_q w_int_clamped;
    pidc_pkg::t_q w_int_next;
    pidc_pkg::t_q w_int_term;
    pidc_pkg::t_wide w_sum;
    pidc_pkg::t_q w_drive;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_int_gain   <= '0;
            r_deriv_gain <= '0;
            r_period_us  <= '0;
            r_int_min    <= '0;
            r_int_max    <= '0;
            r_out_min    <= '0;
            r_out_max    <= '0;
        end else if (i_cfg.valid) begin
            case (pidc_pkg::t_cfg_idx'(i_cfg.index))
                pidc_pkg::CFG_PROP_GAIN:  r_prop_gain  <= i_cfg.data;
                pidc_pkg::CFG_INT_GAIN:   r_int_gain   <= i_cfg.data;
                pidc_pkg::CFG_DERIV_GAIN: r_deriv_gain <= i_cfg.data;
                pidc_pkg::CFG_PERIOD_US:  r_period_us  <= i_cfg.data;
                pidc_pkg::CFG_INT_MIN:    r_int_min    <= i_cfg.data;
                pidc_pkg::CFG_INT_MAX:    r_int_max    <= i_cfg.data;
                pidc_pkg::CFG_OUT_MIN:    r_out_min    <= i_cfg.data;
                pidc_pkg::CFG_OUT_MAX:    r_out_max    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_load     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_meas <= i_in.measurement;
            r_tgt  <= i_in.target;
            r_time <= i_in.time_us;
        end
    end

    // period gate
    assign w_elapsed = r_time - r_last_run_time;
    assign w_run     = w_elapsed >= r_period_us;

    assign w_err  = pidc_pkg::sat(pidc_pkg::ext(r_tgt) - pidc_pkg::ext(r_meas));
    assign w_diff = pidc_pkg::sat(pidc_pkg::ext(w_err) - pidc_pkg::ext(r_last_error));

    pidc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_deriv (
        .i_a (r_deriv_gain),
        .i_b (w_diff),
        .o_y (w_deriv)
    );

    pidc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_prop (
        .i_a (r_prop_gain),
        .i_b (w_err),
        .o_y (w_prop)
    );

    pidc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_int (
        .i_a (r_int_gain),
        .i_b (w_err),
        .o_y (w_inc)
    );

    assign w_int_clamped = pidc_pkg::limit(
        pidc_pkg::sat(pidc_pkg::ext(r_integral_acc) + pidc_pkg::ext(w_inc)),
        r_int_min, r_int_max);

    // zero integral gain freezes the accumulator and drops its term
    assign w_int_next = (r_int_gain != '0) ? w_int_clamped : r_integral_acc;
    assign w_int_term = (r_int_gain != '0) ? w_int_clamped : '0;

    assign w_sum   = pidc_pkg::ext(w_prop) + pidc_pkg::ext(w_int_term)
                   + pidc_pkg::ext(w_deriv);
    assign w_drive = pidc_pkg::limit(pidc_pkg::sat(w_sum), r_out_min, r_out_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error    <= '0;
            r_integral_acc  <= '0;
            r_held_output   <= '0;
            r_held_deriv    <= '0;
            r_last_run_time <= '0;
        end else if (w_load && w_run) begin
            r_last_error    <= w_err;
            r_integral_acc  <= w_int_next;
            r_held_output   <= w_drive;
            r_held_deriv    <= w_deriv;
            r_last_run_time <= r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_run) begin
                r_out_drive <= w_drive;
                r_out_ran   <= 1'b1;
                r_out_error <= w_err;
                r_out_deriv <= w_deriv;
            end else begin
                r_out_drive <= r_held_output;
                r_out_ran   <= 1'b0;
                r_out_error <= r_last_error;
                r_out_deriv <= r_held_deriv;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.drive      = r_out_drive;
    assign o_out.ran        = r_out_ran;
    assign o_out.error_now  = r_out_error;
    assign o_out.deriv_term = r_out_deriv;

    // a pending result always mirrors the held controller state
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_drive == r_held_output) && (r_out_error == r_last_error)
                        && (r_out_deriv == r_held_deriv))
        else $error("pending result differs from held state");

    // a run stamps the sample time and marks the result as ran
    a_run_stamps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_run) |=> (r_last_run_time == $past(r_time)) && r_out_ran)
        else $error("run did not record its timestamp");

    // a skipped sample leaves the controller state untouched
    a_skip_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_run) |=> $stable(r_integral_acc) && $stable(r_last_run_time)
                               && !r_out_ran)
        else $error("skipped sample changed state");

    // the input register only empties into the result register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input beat dropped");

endmodule

### verif/pid_step_with_clamps_top_test.sv
// ----------------------------------------------------------------------------
// pid_step_with_clamps_top_test
// self-checking bench for the clamped pid step: a directed set of edge cases
// (period gate and timestamp wrap, saturating error and products, inverted
// limits, zero integral gain) then randomised register settings and samples,
// with random gaps and stalls on both channels and one long result stall
// ----------------------------------------------------------------------------
module pid_step_with_clamps_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC     = pidc_pkg::FRAC_BITS_DEF;
    localparam longint Q_HI     = 64'sd2147483647;
    localparam longint Q_LO     = -64'sd2147483648;
    localparam int     LIMIT_NS = 400_000;

    typedef struct {
        pidc_pkg::t_q drive;
        logic         ran;
        pidc_pkg::t_q error_now;
        pidc_pkg::t_q deriv_term;
    } t_pid_result;

    class t_drive_checker;
        pidc_pkg::t_q kp, ki, kd, imin, imax, omin, omax;
        bit [31:0]    period;
        pidc_pkg::t_q last_err, integ_acc, held_drive, held_deriv;
        bit [31:0]    last_time;
        t_pid_result  awaited_outputs[$];
        int           failures;

        function new();
            kp = 0; ki = 0; kd = 0; period = 0;
            imin = 0; imax = 0; omin = 0; omax = 0;
            last_err = 0; integ_acc = 0; held_drive = 0; held_deriv = 0;
            last_time = 0;
            failures = 0;
        endfunction

        function pidc_pkg::t_q clip32(longint v);
            if (v > Q_HI) return pidc_pkg::t_q'(Q_HI);
            if (v < Q_LO) return pidc_pkg::t_q'(Q_LO);
            return pidc_pkg::t_q'(v);
        endfunction

        function pidc_pkg::t_q fx_mul(pidc_pkg::t_q a, pidc_pkg::t_q b);
            longint p;
            p = longint'(a) * longint'(b);
            return clip32(p >>> FRAC);
        endfunction

        function pidc_pkg::t_q bound(pidc_pkg::t_q v, pidc_pkg::t_q lo, pidc_pkg::t_q hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void set_reg(pidc_pkg::t_cfg_idx idx, bit [31:0] data);
            case (idx)
                pidc_pkg::CFG_PROP_GAIN:  kp = data;
                pidc_pkg::CFG_INT_GAIN:   ki = data;
                pidc_pkg::CFG_DERIV_GAIN: kd = data;
                pidc_pkg::CFG_PERIOD_US:  period = data;
                pidc_pkg::CFG_INT_MIN:    imin = data;
                pidc_pkg::CFG_INT_MAX:    imax = data;
                pidc_pkg::CFG_OUT_MIN:    omin = data;
                pidc_pkg::CFG_OUT_MAX:    omax = data;
                default: ;
            endcase
        endfunction

        function void note_sample(pidc_pkg::t_q meas, pidc_pkg::t_q tgt, bit [31:0] now);
            t_pid_result  want;
            pidc_pkg::t_q err, diff, deriv, prop, integ, drive;
            bit [31:0]    elapsed;
            elapsed = now - last_time;
            if (elapsed < period) begin
                want.drive      = held_drive;
                want.ran        = 1'b0;
                want.error_now  = last_err;
                want.deriv_term = held_deriv;
            end else begin
                err   = clip32(longint'(tgt) - longint'(meas));
                diff  = clip32(longint'(err) - longint'(last_err));
                deriv = fx_mul(kd, diff);
                prop  = fx_mul(kp, err);
                integ = 0;
                if (ki != 0) begin
                    integ_acc = bound(clip32(longint'(integ_acc) + longint'(fx_mul(ki, err))),
                                      imin, imax);
                    integ = integ_acc;
                end
                drive = bound(clip32(longint'(prop) + longint'(integ) + longint'(deriv)),
                              omin, omax);
                last_err   = err;
                held_deriv = deriv;
                held_drive = drive;
                last_time  = now;
                want.drive      = drive;
                want.ran        = 1'b1;
                want.error_now  = err;
                want.deriv_term = deriv;
            end
            awaited_outputs.push_back(want);
        endfunction

        function void check_beat(pidc_pkg::t_q drive, logic ran, pidc_pkg::t_q error_now,
                                 pidc_pkg::t_q deriv_term);
            t_pid_result want;
            if (awaited_outputs.size() == 0) begin
                flag("result beat with nothing outstanding");
                return;
            end
            want = awaited_outputs.pop_front();
            if (drive !== want.drive || ran !== want.ran || error_now !== want.error_now
                    || deriv_term !== want.deriv_term) begin
                flag($sformatf({"mismatch: expected drive=%0d ran=%0d err=%0d deriv=%0d,",
                                " got drive=%0d ran=%0d err=%0d deriv=%0d"},
                               want.drive, want.ran, want.error_now, want.deriv_term,
                               drive, ran, error_now, deriv_term));
            end
        endfunction

        function void check_drained();
            if (awaited_outputs.size() != 0) begin
                flag($sformatf("%0d results never arrived", awaited_outputs.size()));
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   in_burst;

    pidc_cfg_if cfg_if ();
    pidc_in_if  in_if ();
    pidc_out_if out_if ();

    t_drive_checker sb = new();

    pid_step_with_clamps_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                sb.set_reg(pidc_pkg::t_cfg_idx'(cfg_if.index), cfg_if.data);
            end
            if (in_if.valid && in_if.ready) begin
                sb.note_sample(in_if.measurement, in_if.target, in_if.time_us);
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_beat(out_if.drive, out_if.ran, out_if.error_now, out_if.deriv_term);
            end
        end
    end

    // result side: random stalls, bursts, and one long hold-off
    initial begin : result_sink
        int stall;
        int taken;
        bit rx_burst;
        taken = 0;
        rx_burst = 0;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 64 == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            taken++;
            if (taken == 400) begin
                out_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
        end
    end

    task automatic configure(input bit [31:0] regs [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= pidc_pkg::t_cfg_idx'(i);
            cfg_if.data  <= regs[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_sample(input pidc_pkg::t_q meas, input pidc_pkg::t_q tgt,
                               input bit [31:0] now);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.measurement <= meas;
        in_if.target      <= tgt;
        in_if.time_us     <= now;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.awaited_outputs.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3, 4:    return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic bit [31:0] pick_period();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    function automatic void pick_limits(output bit [31:0] lo, output bit [31:0] hi);
        bit [31:0] a, b;
        a = $urandom();
        b = $urandom();
        case ($urandom_range(0, 5))
            0: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1: begin
                // inverted pair
                if ($signed(a) > $signed(b)) begin
                    lo = a;
                    hi = b;
                end else begin
                    lo = b;
                    hi = a;
                end
            end
            2: begin
                lo = a;
                hi = b;
            end
            default: begin
                lo = 32'd0 - $urandom_range(0, 32'h0032_0000);
                hi = $urandom_range(0, 32'h0032_0000);
            end
        endcase
    endfunction

    function automatic bit [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
        endcase
    endfunction

    function automatic bit [31:0] advance(bit [31:0] now, bit [31:0] period);
        bit [31:0] step;
        if ($urandom_range(0, 15) == 0) begin
            return $urandom();
        end
        if (period > 32'h7FFF_FFFF) begin
            step = $urandom();
        end else begin
            step = $urandom_range(0, period * 2 + 1);
        end
        return now + step;
    endfunction

    initial begin : stimulus
        bit [31:0] regs [8];
        bit [31:0] now;
        in_if.valid       <= 1'b0;
        in_if.measurement <= '0;
        in_if.target      <= '0;
        in_if.time_us     <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= pidc_pkg::CFG_PROP_GAIN;
        cfg_if.data       <= '0;
        in_burst = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // moderate gains, period gate of 100 us
        regs = '{32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'd100,
                 32'hFFF6_0000, 32'h000A_0000, 32'hFFEC_0000, 32'h0014_0000};
        configure(regs);
        send_sample(32'h0000_0000, 32'h0001_0000, 32'd0);
        send_sample(32'h0000_0000, 32'h0001_0000, 32'd99);
        send_sample(32'h0000_0000, 32'h0001_0000, 32'd100);
        send_sample(32'h0000_8000, 32'h0003_0000, 32'd150);
        send_sample(32'h0000_8000, 32'h0003_0000, 32'd199);
        send_sample(32'h0000_8000, 32'h0003_0000, 32'd200);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd300);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd400);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'd500);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd600);
        send_sample(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFF0);
        // timestamp wraps past zero
        send_sample(32'h0000_0001, 32'h0000_0002, 32'h0000_0010);
        send_sample(32'h0000_0001, 32'h0000_0002, 32'h0000_0054);
        drain();

        // zero period, zero integral gain, inverted output and integral limits
        regs = '{32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'd0,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'hFFFB_0000};
        configure(regs);
        send_sample(32'h0000_0000, 32'h0002_0000, 32'd5);
        send_sample(32'h0000_0000, 32'hFFFE_0000, 32'd5);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        send_sample(32'h0000_1234, 32'h0000_1234, 32'd2);
        drain();

        // largest period, extreme gains, inverted integral limits
        regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'h0003_0000, 32'hFFFD_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        configure(regs);
        send_sample(32'h0001_0000, 32'h0000_0000, 32'd3);
        send_sample(32'h0001_0000, 32'h0000_0000, 32'd1);
        send_sample(32'hFFFF_0000, 32'h7FFF_0000, 32'd0);
        send_sample(32'h0000_0005, 32'hFFFF_FFFB, 32'hFFFF_FFFF);
        send_sample(32'h0000_0005, 32'hFFFF_FFFB, 32'd7);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            regs[pidc_pkg::CFG_PROP_GAIN]  = pick_gain();
            regs[pidc_pkg::CFG_INT_GAIN]   = pick_gain();
            regs[pidc_pkg::CFG_DERIV_GAIN] = pick_gain();
            regs[pidc_pkg::CFG_PERIOD_US]  = pick_period();
            pick_limits(regs[pidc_pkg::CFG_INT_MIN], regs[pidc_pkg::CFG_INT_MAX]);
            pick_limits(regs[pidc_pkg::CFG_OUT_MIN], regs[pidc_pkg::CFG_OUT_MAX]);
            configure(regs);
            now = $urandom();
            for (int n = 0; n < 119; n++) begin
                if (n % 40 == 0) begin
                    in_burst = ($urandom_range(0, 3) == 0);
                end
                now = advance(now, regs[pidc_pkg::CFG_PERIOD_US]);
                send_sample(pick_sample(), pick_sample(), now);
            end
            in_burst = 0;
            drain();
        end

        sb.check_drained();
        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/pidc_pkg.sv
rtl/pidc_if.sv
rtl/pidc_qmul.sv
rtl/pid_step_with_clamps_top.sv
verif/pid_step_with_clamps_top_test.sv
